[hw/rtl/kest_pkg.sv]
`timescale 1ns / 1ps

package kest_pkg;

  localparam int NUM_KEYS    = 128;
  localparam int NUM_BUTTONS = 8;
  localparam int MOD_BITS    = 8;

  localparam int TBL_DEPTH = NUM_KEYS + NUM_BUTTONS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int CNT_W     = $clog2(TBL_DEPTH + 1);

  localparam int FUNC_W  = 4;
  localparam int CODE_W  = 7;
  localparam int POS_W   = 16;
  localparam int WHEEL_W = 8;
  localparam int MODS_W  = 8;
  localparam int DELTA_W = 17;
  localparam int SUM_W   = 16;

  localparam logic [MODS_W-1:0] NO_MODS  = '0;
  localparam logic [MODS_W-1:0] MOD_MASK = MODS_W'((64'd1 << MOD_BITS) - 64'd1);
  localparam logic [TBL_AW-1:0] BTN_BASE = TBL_AW'(NUM_KEYS);

  localparam logic [FUNC_W-1:0] FN_KEY_DOWN = 4'd0;
  localparam logic [FUNC_W-1:0] FN_KEY_UP   = 4'd1;
  localparam logic [FUNC_W-1:0] FN_BTN_DOWN = 4'd2;
  localparam logic [FUNC_W-1:0] FN_BTN_UP   = 4'd3;
  localparam logic [FUNC_W-1:0] FN_ENTER    = 4'd4;
  localparam logic [FUNC_W-1:0] FN_MOVE     = 4'd5;
  localparam logic [FUNC_W-1:0] FN_WHEEL    = 4'd6;
  localparam logic [FUNC_W-1:0] FN_FOCUS    = 4'd7;
  localparam logic [FUNC_W-1:0] FN_FRAME    = 4'd8;
  localparam logic [FUNC_W-1:0] FN_QRY_KEY  = 4'd9;
  localparam logic [FUNC_W-1:0] FN_QRY_BTN  = 4'd10;

  typedef enum logic [1:0] {
    ST_UP       = 2'd0,
    ST_DOWN     = 2'd1,
    ST_PRESSED  = 2'd2,
    ST_RELEASED = 2'd3
  } entry_st_t;

endpackage

[hw/rtl/key_edge_state_tracker_top.sv]
`timescale 1ns / 1ps
// Takes one input transaction at a time: in_stall stays high until its result is
// registered, which waits while out_stall holds a pending result; end of frame adds
// a settle sweep over all NUM_KEYS+NUM_BUTTONS entries, focus lost a clear sweep.
// Both sweeps run through the single state table RAM, one entry per cycle.
// Reset: synchronous; a clear pass over all table entries follows, in_stall high.
module key_edge_state_tracker_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [kest_pkg::FUNC_W-1:0]         in_func,
  input  logic [kest_pkg::CODE_W-1:0]         in_code,
  input  logic signed [kest_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [kest_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [kest_pkg::WHEEL_W-1:0] in_wheel_step,
  input  logic [kest_pkg::MODS_W-1:0]         in_mods_in,
  input  logic                                in_focused,
  input  logic [kest_pkg::MODS_W-1:0]         in_mod_query,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_entry_down,
  output logic                                out_entry_pressed,
  output logic                                out_entry_released,
  output logic signed [kest_pkg::POS_W-1:0]   out_pointer_x,
  output logic signed [kest_pkg::POS_W-1:0]   out_pointer_y,
  output logic signed [kest_pkg::DELTA_W-1:0] out_delta_x,
  output logic signed [kest_pkg::DELTA_W-1:0] out_delta_y,
  output logic signed [kest_pkg::SUM_W-1:0]   out_wheel_total,
  output logic [kest_pkg::MODS_W-1:0]         out_mods_now,
  output logic                                out_mods_match
);

  import kest_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SETTLE,
    S_DONE
  } state_t;

  function automatic entry_st_t press_f(entry_st_t e);
    press_f = (e == ST_DOWN || e == ST_PRESSED) ? e : ST_PRESSED;
  endfunction

  function automatic entry_st_t release_f(entry_st_t e);
    release_f = (e == ST_DOWN || e == ST_PRESSED) ? ST_RELEASED : e;
  endfunction

  function automatic entry_st_t settle_f(entry_st_t e);
    case (e)
      ST_PRESSED:  settle_f = ST_DOWN;
      ST_RELEASED: settle_f = ST_UP;
      default:     settle_f = e;
    endcase
  endfunction

  state_t                    state_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      clr_ret_r;

  logic [FUNC_W-1:0]         func_r;
  logic                      hit_r;
  logic [TBL_AW-1:0]         addr_r;
  logic signed [POS_W-1:0]   pos_x_r;
  logic signed [POS_W-1:0]   pos_y_r;
  logic signed [WHEEL_W-1:0] wheel_step_r;
  logic [MODS_W-1:0]         mods_in_r;
  logic                      focused_r;
  logic [MODS_W-1:0]         mod_query_r;

  logic signed [POS_W-1:0]   cur_x_r;
  logic signed [POS_W-1:0]   cur_y_r;
  logic signed [POS_W-1:0]   last_x_r;
  logic signed [POS_W-1:0]   last_y_r;
  logic signed [SUM_W-1:0]   wheel_r;
  logic [MODS_W-1:0]         mods_r;
  entry_st_t                 ent_res_r;

  logic                      out_valid_r;
  logic                      out_down_r;
  logic                      out_pressed_r;
  logic                      out_released_r;
  logic signed [POS_W-1:0]   out_px_r;
  logic signed [POS_W-1:0]   out_py_r;
  logic signed [DELTA_W-1:0] out_dx_r;
  logic signed [DELTA_W-1:0] out_dy_r;
  logic signed [SUM_W-1:0]   out_wheel_r;
  logic [MODS_W-1:0]         out_mods_r;
  logic                      out_match_r;

  logic                      in_acc;
  logic                      in_is_key;
  logic                      in_is_btn;
  logic                      in_hit;
  logic [TBL_AW-1:0]         in_addr;

  logic                      ram_we;
  logic [TBL_AW-1:0]         ram_waddr;
  logic [1:0]                ram_wdata;
  logic [TBL_AW-1:0]         ram_raddr;
  logic [1:0]                ram_rdata;

  entry_st_t                 ent_cur;
  entry_st_t                 ent_new;
  logic signed [SUM_W:0]     wsum;
  logic signed [SUM_W-1:0]   wsat;
  logic                      out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign in_is_key = (in_func inside {FN_KEY_DOWN, FN_KEY_UP, FN_QRY_KEY});
  assign in_is_btn = (in_func inside {FN_BTN_DOWN, FN_BTN_UP, FN_QRY_BTN});
  assign in_hit    = (in_is_key && (32'(in_code) < NUM_KEYS))
                  || (in_is_btn && (32'(in_code) < NUM_BUTTONS));
  assign in_addr   = in_is_btn ? TBL_AW'(BTN_BASE + TBL_AW'(in_code)) : TBL_AW'(in_code);

  assign ent_cur = entry_st_t'(ram_rdata);

  always_comb begin
    case (func_r)
      FN_KEY_DOWN, FN_BTN_DOWN: ent_new = press_f(ent_cur);
      FN_KEY_UP, FN_BTN_UP:     ent_new = release_f(ent_cur);
      default:                  ent_new = ent_cur;
    endcase
  end

  always_comb begin
    wsum = {wheel_r[SUM_W-1], wheel_r}
         + {{(SUM_W + 1 - WHEEL_W){wheel_step_r[WHEEL_W-1]}}, wheel_step_r};
    if (wsum > 17'sd32767) begin
      wsat = 16'sh7fff;
    end else if (wsum < -17'sd32768) begin
      wsat = 16'sh8000;
    end else begin
      wsat = wsum[SUM_W-1:0];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = ent_new;
    ram_raddr = in_addr;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[TBL_AW-1:0];
        ram_wdata = ST_UP;
      end
      S_READ: begin
        ram_we = hit_r && (func_r inside {FN_KEY_DOWN, FN_KEY_UP, FN_BTN_DOWN, FN_BTN_UP});
      end
      S_SETTLE: begin
        ram_raddr = cnt_r[TBL_AW-1:0];
        ram_we    = (cnt_r != '0);
        ram_waddr = TBL_AW'(cnt_r - CNT_W'(1));
        ram_wdata = settle_f(ent_cur);
      end
      default: begin
      end
    endcase
  end

  kest_ram #(
    .WIDTH (2),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      clr_ret_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      wheel_r     <= '0;
      mods_r      <= NO_MODS;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (cnt_r == CNT_W'(TBL_DEPTH - 1)) begin
            state_r <= clr_ret_r ? S_DONE : S_IDLE;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            func_r       <= in_func;
            hit_r        <= in_hit;
            addr_r       <= in_addr;
            pos_x_r      <= in_pos_x;
            pos_y_r      <= in_pos_y;
            wheel_step_r <= in_wheel_step;
            mods_in_r    <= in_mods_in & MOD_MASK;
            focused_r    <= in_focused;
            mod_query_r  <= in_mod_query;
            state_r      <= S_READ;
          end
        end
        S_READ: begin
          ent_res_r <= hit_r ? ent_new : ST_UP;
          cnt_r     <= '0;
          if (func_r inside {FN_KEY_DOWN, FN_KEY_UP, FN_BTN_DOWN, FN_BTN_UP}) begin
            mods_r <= mods_in_r;
          end
          if (func_r inside {FN_BTN_DOWN, FN_BTN_UP, FN_ENTER, FN_MOVE}) begin
            cur_x_r <= pos_x_r;
            cur_y_r <= pos_y_r;
          end
          case (func_r)
            FN_ENTER: begin
              last_x_r <= pos_x_r;
              last_y_r <= pos_y_r;
              state_r  <= S_DONE;
            end
            FN_WHEEL: begin
              wheel_r <= wsat;
              state_r <= S_DONE;
            end
            FN_FOCUS: begin
              if (!focused_r) begin
                wheel_r   <= '0;
                mods_r    <= NO_MODS;
                clr_ret_r <= 1'b1;
                state_r   <= S_CLEAR;
              end else begin
                state_r   <= S_DONE;
              end
            end
            FN_FRAME: begin
              wheel_r  <= '0;
              last_x_r <= cur_x_r;
              last_y_r <= cur_y_r;
              state_r  <= S_SETTLE;
            end
            default: begin
              state_r <= S_DONE;
            end
          endcase
        end
        S_SETTLE: begin
          if (cnt_r == CNT_W'(TBL_DEPTH)) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_down_r     <= (ent_res_r == ST_DOWN) || (ent_res_r == ST_PRESSED);
            out_pressed_r  <= (ent_res_r == ST_PRESSED);
            out_released_r <= (ent_res_r == ST_RELEASED);
            out_px_r       <= cur_x_r;
            out_py_r       <= cur_y_r;
            out_dx_r       <= {cur_x_r[POS_W-1], cur_x_r} - {last_x_r[POS_W-1], last_x_r};
            out_dy_r       <= {cur_y_r[POS_W-1], cur_y_r} - {last_y_r[POS_W-1], last_y_r};
            out_wheel_r    <= wheel_r;
            out_mods_r     <= mods_r;
            out_match_r    <= (mod_query_r != NO_MODS)
                           && ((mods_r & mod_query_r) == mod_query_r);
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_entry_down     = out_down_r;
  assign out_entry_pressed  = out_pressed_r;
  assign out_entry_released = out_released_r;
  assign out_pointer_x      = out_px_r;
  assign out_pointer_y      = out_py_r;
  assign out_delta_x        = out_dx_r;
  assign out_delta_y        = out_dy_r;
  assign out_wheel_total    = out_wheel_r;
  assign out_mods_now       = out_mods_r;
  assign out_mods_match     = out_match_r;

endmodule

[hw/rtl/kest_ram.sv]
`timescale 1ns / 1ps

module kest_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 136
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[bench/key_edge_state_tracker_top_test.sv]
`timescale 1ns / 1ps

module key_edge_state_tracker_top_test;
  import kest_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 4'd11;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 4'd15;
  localparam int N_RANDOM   = 1600;
  localparam int STORM_LEN  = 280;
  localparam int HOLD_CYCLES = 400;
  localparam longint LIMIT_NS = 64'd20_000_000;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [CODE_W-1:0]         code;
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
    logic signed [WHEEL_W-1:0] step;
    logic [MODS_W-1:0]         mods;
    logic                      focused;
    logic [MODS_W-1:0]         query;
  } kbd_event_t;

  typedef struct packed {
    logic                      down;
    logic                      pressed;
    logic                      released;
    logic signed [POS_W-1:0]   ptr_x;
    logic signed [POS_W-1:0]   ptr_y;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [SUM_W-1:0]   wheel;
    logic [MODS_W-1:0]         mods;
    logic                      match;
  } tracker_view_t;

  typedef struct packed {
    kbd_event_t    ev;
    logic          typed;
    tracker_view_t view;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FUNC_W-1:0] in_func = '0;
  logic [CODE_W-1:0] in_code = '0;
  logic signed [POS_W-1:0] in_pos_x = '0;
  logic signed [POS_W-1:0] in_pos_y = '0;
  logic signed [WHEEL_W-1:0] in_wheel_step = '0;
  logic [MODS_W-1:0] in_mods_in = '0;
  logic in_focused = 1'b1;
  logic [MODS_W-1:0] in_mod_query = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_entry_down;
  logic out_entry_pressed;
  logic out_entry_released;
  logic signed [POS_W-1:0] out_pointer_x;
  logic signed [POS_W-1:0] out_pointer_y;
  logic signed [DELTA_W-1:0] out_delta_x;
  logic signed [DELTA_W-1:0] out_delta_y;
  logic signed [SUM_W-1:0] out_wheel_total;
  logic [MODS_W-1:0] out_mods_now;
  logic out_mods_match;

  key_edge_state_tracker_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_code            (in_code),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_wheel_step      (in_wheel_step),
    .in_mods_in         (in_mods_in),
    .in_focused         (in_focused),
    .in_mod_query       (in_mod_query),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_entry_down     (out_entry_down),
    .out_entry_pressed  (out_entry_pressed),
    .out_entry_released (out_entry_released),
    .out_pointer_x      (out_pointer_x),
    .out_pointer_y      (out_pointer_y),
    .out_delta_x        (out_delta_x),
    .out_delta_y        (out_delta_y),
    .out_wheel_total    (out_wheel_total),
    .out_mods_now       (out_mods_now),
    .out_mods_match     (out_mods_match)
  );

  always #5 clk = ~clk;

  // predictor state
  entry_st_t               key_st [NUM_KEYS];
  entry_st_t               btn_st [NUM_BUTTONS];
  logic signed [POS_W-1:0] ptr_x, ptr_y, ref_x, ref_y;
  logic signed [SUM_W-1:0] wheel_acc;
  logic [MODS_W-1:0]       mods_now;

  tracker_view_t view_q[$];
  dir_row_t      dir_tab[$];
  int  mismatch_cnt = 0;
  int  ev_sent = 0;
  int  rx_wait = 0;
  bit  hold_off = 1'b0;
  bit  idle_en = 1'b1;

  function automatic kbd_event_t key_event(
    input logic [FUNC_W-1:0] func, input logic [CODE_W-1:0] code,
    input logic [POS_W-1:0] x, input logic [POS_W-1:0] y, input logic [WHEEL_W-1:0] step,
    input logic [MODS_W-1:0] mods, input logic focused, input logic [MODS_W-1:0] query);
    kbd_event_t e;
    e = '{func, code, x, y, step, mods, focused, query};
    return e;
  endfunction

  function automatic tracker_view_t tracker_view(
    input logic down, input logic pressed, input logic released,
    input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
    input logic [DELTA_W-1:0] dx, input logic [DELTA_W-1:0] dy,
    input logic [SUM_W-1:0] wheel, input logic [MODS_W-1:0] mods, input logic match);
    tracker_view_t v;
    v = '{down, pressed, released, px, py, dx, dy, wheel, mods, match};
    return v;
  endfunction

  function automatic void clear_tracker();
    foreach (key_st[i]) key_st[i] = ST_UP;
    foreach (btn_st[i]) btn_st[i] = ST_UP;
    wheel_acc = '0;
    mods_now  = NO_MODS;
  endfunction

  function automatic tracker_view_t track_event(input kbd_event_t e);
    tracker_view_t v;
    entry_st_t st;
    bit on_key, on_btn;
    int acc;
    on_key = (e.func == FN_KEY_DOWN || e.func == FN_KEY_UP || e.func == FN_QRY_KEY) &&
             (int'(e.code) < NUM_KEYS);
    on_btn = (e.func == FN_BTN_DOWN || e.func == FN_BTN_UP || e.func == FN_QRY_BTN) &&
             (int'(e.code) < NUM_BUTTONS);
    st = ST_UP;
    if (on_key) st = key_st[e.code];
    else if (on_btn) st = btn_st[e.code];
    if (on_key || on_btn) begin
      if ((e.func == FN_KEY_DOWN || e.func == FN_BTN_DOWN) &&
          st != ST_DOWN && st != ST_PRESSED) st = ST_PRESSED;
      if ((e.func == FN_KEY_UP || e.func == FN_BTN_UP) &&
          (st == ST_DOWN || st == ST_PRESSED)) st = ST_RELEASED;
      if (on_key) key_st[e.code] = st;
      else btn_st[e.code] = st;
    end
    if (e.func <= FN_BTN_UP) mods_now = e.mods & MOD_MASK;
    if (e.func >= FN_BTN_DOWN && e.func <= FN_MOVE) begin
      ptr_x = e.x;
      ptr_y = e.y;
    end
    if (e.func == FN_ENTER) begin
      ref_x = e.x;
      ref_y = e.y;
    end
    if (e.func == FN_WHEEL) begin
      acc = $signed(wheel_acc) + $signed(e.step);
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      wheel_acc = SUM_W'(acc);
    end
    if (e.func == FN_FOCUS && !e.focused) clear_tracker();
    if (e.func == FN_FRAME) begin
      foreach (key_st[i]) begin
        if (key_st[i] == ST_PRESSED) key_st[i] = ST_DOWN;
        else if (key_st[i] == ST_RELEASED) key_st[i] = ST_UP;
      end
      foreach (btn_st[i]) begin
        if (btn_st[i] == ST_PRESSED) btn_st[i] = ST_DOWN;
        else if (btn_st[i] == ST_RELEASED) btn_st[i] = ST_UP;
      end
      wheel_acc = '0;
      ref_x = ptr_x;
      ref_y = ptr_y;
    end
    v.down     = (st == ST_DOWN || st == ST_PRESSED);
    v.pressed  = (st == ST_PRESSED);
    v.released = (st == ST_RELEASED);
    v.ptr_x    = ptr_x;
    v.ptr_y    = ptr_y;
    v.dx       = {ptr_x[POS_W-1], ptr_x} - {ref_x[POS_W-1], ref_x};
    v.dy       = {ptr_y[POS_W-1], ptr_y} - {ref_y[POS_W-1], ref_y};
    v.wheel    = wheel_acc;
    v.mods     = mods_now;
    v.match    = (e.query != NO_MODS) && ((mods_now & e.query) == e.query);
    return v;
  endfunction

  function automatic kbd_event_t rand_event(input logic [FUNC_W-1:0] func);
    kbd_event_t e;
    logic [MODS_W-1:0] ref_mods;
    e.func = func;
    if (func == FN_BTN_DOWN || func == FN_BTN_UP || func == FN_QRY_BTN)
      e.code = ($urandom_range(0, 7) != 0) ? CODE_W'($urandom_range(0, NUM_BUTTONS - 1))
                                           : CODE_W'($urandom);
    else
      e.code = ($urandom_range(0, 1) != 0) ? CODE_W'($urandom_range(0, 7)) : CODE_W'($urandom);
    e.x       = POS_W'($urandom);
    e.y       = POS_W'($urandom);
    e.step    = WHEEL_W'($urandom);
    e.mods    = MODS_W'($urandom);
    e.focused = ($urandom_range(0, 7) != 0);
    ref_mods  = (func <= FN_BTN_UP) ? e.mods : mods_now;
    e.query   = ($urandom_range(0, 2) == 0) ? MODS_W'($urandom) : (ref_mods & MODS_W'($urandom));
    return e;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_cnt++;
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic offer_event(input kbd_event_t e, input bit use_typed,
                             input tracker_view_t typed_view);
    int gap;
    tracker_view_t v;
    gap = idle_en ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_func       <= e.func;
    in_code       <= e.code;
    in_pos_x      <= e.x;
    in_pos_y      <= e.y;
    in_wheel_step <= e.step;
    in_mods_in    <= e.mods;
    in_focused    <= e.focused;
    in_mod_query  <= e.query;
    do @(posedge clk); while (in_stall);
    v = track_event(e);
    view_q.push_back(use_typed ? typed_view : v);
    ev_sent++;
  endtask

  task automatic run_frame();
    int len;
    kbd_event_t e;
    len = $urandom_range(1, 12);
    repeat (len) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3: e = rand_event(FN_KEY_DOWN);
        4, 5, 15:   e = rand_event(FN_KEY_UP);
        6, 7:       e = rand_event(FN_BTN_DOWN);
        8:          e = rand_event(FN_BTN_UP);
        9:          e = rand_event(FN_MOVE);
        10:         e = rand_event(FN_ENTER);
        11:         e = rand_event(FN_WHEEL);
        12:         e = rand_event(FN_QRY_KEY);
        13:         e = rand_event(FN_QRY_BTN);
        default:    e = rand_event(FN_FOCUS);
      endcase
      offer_event(e, 1'b0, '0);
    end
    offer_event(rand_event(FN_FRAME), 1'b0, '0);
  endtask

  task automatic run_wheel_storm(input bit upward);
    kbd_event_t e;
    repeat (STORM_LEN) begin
      e = rand_event(FN_WHEEL);
      e.step = upward ? WHEEL_W'($urandom_range(112, 127))
                      : WHEEL_W'(-int'($urandom_range(112, 128)));
      offer_event(e, 1'b0, '0);
    end
    repeat (4) begin
      e = rand_event(FN_WHEEL);
      e.step = upward ? WHEEL_W'(-int'($urandom_range(1, 128)))
                      : WHEEL_W'($urandom_range(1, 127));
      offer_event(e, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    if (hold_off || rx_wait != 0) out_stall <= 1'b1;
    else out_stall <= 1'b0;
    if (!hold_off && rx_wait != 0) rx_wait = rx_wait - 1;
  end

  always @(posedge clk) begin : result_check
    tracker_view_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_entry_down, out_entry_pressed, out_entry_released, out_pointer_x,
              out_pointer_y, out_delta_x, out_delta_y, out_wheel_total, out_mods_now,
              out_mods_match};
      if (view_q.size() == 0) begin
        report_mismatch("transaction with nothing expected", '0, '0);
      end else begin
        want = view_q.pop_front();
        if (got.down !== want.down) report_mismatch("entry_down", got.down, want.down);
        if (got.pressed !== want.pressed)
          report_mismatch("entry_pressed", got.pressed, want.pressed);
        if (got.released !== want.released)
          report_mismatch("entry_released", got.released, want.released);
        if (got.ptr_x !== want.ptr_x) report_mismatch("pointer_x", got.ptr_x, want.ptr_x);
        if (got.ptr_y !== want.ptr_y) report_mismatch("pointer_y", got.ptr_y, want.ptr_y);
        if (got.dx !== want.dx) report_mismatch("delta_x", got.dx, want.dx);
        if (got.dy !== want.dy) report_mismatch("delta_y", got.dy, want.dy);
        if (got.wheel !== want.wheel) report_mismatch("wheel_total", got.wheel, want.wheel);
        if (got.mods !== want.mods) report_mismatch("mods_now", got.mods, want.mods);
        if (got.match !== want.match) report_mismatch("mods_match", got.match, want.match);
      end
      rx_wait = idle_en ? $urandom_range(0, 7) : 0;
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("key_edge_state_tracker_top test failed");
    $finish;
  end

  initial begin
    int pick;
    int dir_n;
    bit storm_up_done, storm_dn_done;
    kbd_event_t e;
    storm_up_done = 1'b0;
    storm_dn_done = 1'b0;
    ptr_x = '0;
    ptr_y = '0;
    ref_x = '0;
    ref_y = '0;
    clear_tracker();

    // opening rows carry hand-computed results
    dir_tab.push_back('{key_event(FN_QRY_KEY, 0, 0, 0, 0, 8'hFF, 1, 8'h00), 1'b1,
                        tracker_view(0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0)});
    dir_tab.push_back('{key_event(FN_KEY_DOWN, 127, 16'h1234, 0, 0, 8'hFF, 1, 8'hFF), 1'b1,
                        tracker_view(1, 1, 0, 0, 0, 0, 0, 0, 8'hFF, 1)});
    dir_tab.push_back('{key_event(FN_KEY_UP, 127, 0, 0, 0, 8'h00, 1, 8'h01), 1'b1,
                        tracker_view(0, 0, 1, 0, 0, 0, 0, 0, 8'h00, 0)});
    dir_tab.push_back('{key_event(FN_QRY_KEY, 127, 0, 0, 0, 8'h00, 1, 8'h00), 1'b1,
                        tracker_view(0, 0, 1, 0, 0, 0, 0, 0, 8'h00, 0)});
    dir_tab.push_back('{key_event(FN_BTN_DOWN, 7, 16'h7FFF, 16'h8000, 0, 8'h81, 1, 8'h80), 1'b1,
                        tracker_view(1, 1, 0, 16'h7FFF, 16'h8000, 17'h07FFF, 17'h18000, 0,
                                     8'h81, 1)});
    dir_tab.push_back('{key_event(FN_BTN_UP, 0, 16'h8000, 16'h7FFF, 0, 8'h00, 1, 8'h00), 1'b1,
                        tracker_view(0, 0, 0, 16'h8000, 16'h7FFF, 17'h18000, 17'h07FFF, 0,
                                     8'h00, 0)});
    dir_tab.push_back('{key_event(FN_BTN_DOWN, 8, 5, -5, 0, 8'h03, 1, 8'h03), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_QRY_BTN, 127, 0, 0, 0, 0, 1, 8'h02), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_ENTER, 0, 16'h7FFF, 16'h8000, 0, 0, 1, 0), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_MOVE, 0, 16'h8000, 16'h7FFF, 0, 0, 1, 0), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_WHEEL, 0, 0, 0, 8'h7F, 0, 1, 0), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_WHEEL, 0, 0, 0, 8'h80, 0, 1, 0), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_KEY_DOWN, 5, 0, 0, 0, 8'h10, 1, 8'h10), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_KEY_DOWN, 5, 0, 0, 0, 8'h10, 1, 8'h11), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_FRAME, 0, 0, 0, 0, 0, 1, 8'h10), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_QRY_KEY, 5, 0, 0, 0, 0, 1, 0), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_KEY_UP, 5, 0, 0, 0, 8'h20, 1, 0), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_KEY_DOWN, 5, 0, 0, 0, 8'h20, 1, 8'h20), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_QRY_BTN, 7, 0, 0, 0, 0, 1, 0), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_FOCUS, 0, 0, 0, 0, 0, 1, 8'h20), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_WHEEL, 0, 0, 0, 8'h80, 0, 1, 0), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_FOCUS, 0, 0, 0, 0, 0, 0, 8'h20), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_QRY_KEY, 5, 0, 0, 0, 0, 1, 0), 1'b0, '0});
    dir_tab.push_back('{key_event(FN_SPARE_HI, 3, 16'h1111, 16'h2222, 8'h33, 8'h44, 0, 8'h00),
                        1'b0, '0});
    dir_tab.push_back('{key_event(FN_SPARE_LO, 1, 16'h5555, 16'h6666, 8'h77, 8'h88, 1, 8'h00),
                        1'b0, '0});
    dir_n = dir_tab.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) offer_event(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].view);

    // receiver holds off while the sender keeps pushing, so the block backs up
    fork
      begin
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none

    while (ev_sent < dir_n + N_RANDOM) begin
      idle_en = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (!storm_up_done && ev_sent > dir_n + N_RANDOM / 3) begin
        run_wheel_storm(1'b1);
        storm_up_done = 1'b1;
      end else if (!storm_dn_done && ev_sent > dir_n + 2 * N_RANDOM / 3) begin
        run_wheel_storm(1'b0);
        storm_dn_done = 1'b1;
      end else if (pick < 2) begin
        repeat ($urandom_range(1, 6)) begin
          e = rand_event(FUNC_W'($urandom));
          e.code = CODE_W'($urandom);
          e.focused = $urandom_range(0, 1);
          offer_event(e, 1'b0, '0);
        end
      end else begin
        run_frame();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (view_q.size() != 0) @(posedge clk);
    repeat (NUM_KEYS + NUM_BUTTONS + 8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("key_edge_state_tracker_top test passed");
    end else begin
      $display("key_edge_state_tracker_top test failed");
    end
    $finish;
  end

endmodule
